// ===== rtl/wcht_pkg.sv =====
// Shared types and constants for the word-count hash table.
// Holds the input and result transaction structs and table geometry.
// No dependencies.
`timescale 1ns / 1ps

package wcht_pkg;

    // Table geometry: home slot is the low SLOT_BITS bits of the hash.
    localparam int unsigned SLOT_BITS   = 10;
    localparam int unsigned TABLE_SLOTS = 1 << SLOT_BITS;
    localparam int unsigned PROBE_BITS  = SLOT_BITS + 1;

    // Key storage: up to eight bytes per word.
    localparam int unsigned KEY_BYTES = 8;
    localparam int unsigned KEY_BITS  = 8 * KEY_BYTES;
    localparam int unsigned HASH_BITS = 32;
    localparam int unsigned CNT_BITS  = 32;

    localparam logic [HASH_BITS-1:0] HASH_MULT = 32'd37;

    // ASCII codes used by the byte classifier.
    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_FOLD  = 8'h20;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_text;
    } in_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0] slot;
        logic [CNT_BITS-1:0]  count;
        logic                 is_new;
        logic                 truncated;
        logic                 table_full;
        logic [3:0]           word_length;
    } out_t;

endpackage

// ===== rtl/word_count_hash_table.sv =====
// Word-count hash table top level: byte gatherer, probe sequencer and table memory.
// Depends on wcht_pkg for transaction types and table geometry.
`timescale 1ns / 1ps

// Usage
//   s_valid/s_ready/s_data carry one text byte per transaction (ch, end_of_text).
//   m_valid/m_ready/m_data carry one result per finished word (slot, count,
//   is_new, truncated, table_full, word_length).
//   A byte that does not end a word is taken while the sequencer is idle;
//   s_ready stays high, so such bytes can follow back to back. A byte that
//   ends a non-empty word starts a linear probe of the table memory: each
//   probe is a registered read (S_READ), then a compare/update (S_CHECK),
//   for P = 1..1024 probes, then the hand-off state (S_OUT), which waits while
//   the output register is full. s_ready stays low from the first probe until
//   the hand-off is done, so the block takes no new byte while a word is being
//   probed.
//   After aresetn is released, a clearing pass writes every one of the 1024
//   slots empty, one per cycle; s_ready stays low until the pass ends.
//   The result is held in an output register. The next byte is accepted while
//   a result waits; a second result waits in the sequencer until m_ready frees
//   the output register, and s_ready stays low meanwhile.
module word_count_hash_table #(
    parameter int unsigned MAX_WORD_BYTES = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  wcht_pkg::in_t     s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output wcht_pkg::out_t    m_data
);

    localparam int unsigned SB = wcht_pkg::SLOT_BITS;
    localparam int unsigned PB = wcht_pkg::PROBE_BITS;
    localparam int unsigned KB = wcht_pkg::KEY_BITS;
    localparam int unsigned HB = wcht_pkg::HASH_BITS;
    localparam int unsigned CB = wcht_pkg::CNT_BITS;

    localparam logic [3:0]    MAX_LEN   = 4'(MAX_WORD_BYTES);
    localparam logic [SB-1:0] LAST_SLOT = SB'(wcht_pkg::TABLE_SLOTS - 1);
    localparam logic [PB-1:0] LAST_PROBE = PB'(wcht_pkg::TABLE_SLOTS - 1);
    localparam logic [PB-1:0] SLOT_TOTAL = PB'(wcht_pkg::TABLE_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_OUT
    } state_t;

    // One table entry: occupancy flag, packed key, count.
    typedef struct packed {
        logic          occupied;
        logic [KB-1:0] key;
        logic [CB-1:0] count;
    } entry_t;

    state_t          state_reg;
    logic [SB-1:0]   clr_idx_reg;
    logic [SB-1:0]   probe_idx_reg;
    logic [PB-1:0]   probe_cnt_reg;
    logic [PB-1:0]   entries_used_reg;

    // Word being gathered.
    logic [KB-1:0]   word_reg;
    logic [3:0]      word_len_reg;
    logic [HB-1:0]   hash_reg;
    logic            ovf_reg;

    wcht_pkg::out_t  res_reg;
    logic            m_valid_reg;
    wcht_pkg::out_t  m_data_reg;

    // Table memory, single write port, registered read.
    entry_t          table_mem [wcht_pkg::TABLE_SLOTS];
    entry_t          rd_entry_reg;
    logic            mem_we;
    logic [SB-1:0]   mem_addr;
    entry_t          mem_wdata;

    // Byte path.
    logic [7:0]      ch_fold;
    logic            is_sep;
    logic            word_ends;
    logic [KB-1:0]   word_next;
    logic [3:0]      word_len_next;
    logic [HB-1:0]   hash_next;
    logic            ovf_next;

    // Probe path.
    logic            key_hit;
    logic [CB-1:0]   cnt_sat_inc;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    //--------------------------------------------------------------------
    // Classify and fold the incoming byte, append it to the word.
    //--------------------------------------------------------------------
    always_comb begin
        ch_fold = s_data.ch;
        if (s_data.ch inside {[wcht_pkg::CH_UPPER_A:wcht_pkg::CH_UPPER_Z]}) begin
            ch_fold = s_data.ch + wcht_pkg::CASE_FOLD;
        end
        is_sep = (s_data.ch == wcht_pkg::CH_NUL) || (s_data.ch == wcht_pkg::CH_SPACE) ||
                 (s_data.ch inside {[wcht_pkg::CH_TAB:wcht_pkg::CH_CR]});
        word_ends = is_sep || s_data.end_of_text;

        word_next     = word_reg;
        word_len_next = word_len_reg;
        hash_next     = hash_reg;
        ovf_next      = ovf_reg;
        if (!is_sep) begin
            if (word_len_reg < MAX_LEN) begin
                // Drop the byte into the lane that matches the current length.
                for (int i = 0; i < wcht_pkg::KEY_BYTES; i++) begin
                    if (word_len_reg[2:0] == 3'(i)) begin
                        word_next[8*i +: 8] = ch_fold;
                    end
                end
                word_len_next = word_len_reg + 4'd1;
                hash_next     = HB'(hash_reg * wcht_pkg::HASH_MULT) + HB'(ch_fold);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    //--------------------------------------------------------------------
    // Compare the fetched entry and build the memory write.
    //--------------------------------------------------------------------
    always_comb begin
        key_hit     = (rd_entry_reg.key == word_reg);
        cnt_sat_inc = (rd_entry_reg.count == {CB{1'b1}}) ? rd_entry_reg.count
                                                         : rd_entry_reg.count + CB'(1);
        mem_we    = 1'b0;
        mem_addr  = probe_idx_reg;
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR: begin
                // Mark every slot empty after reset.
                mem_we   = 1'b1;
                mem_addr = clr_idx_reg;
            end
            S_CHECK: begin
                if (!rd_entry_reg.occupied) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{occupied: 1'b1, key: word_reg, count: CB'(1)};
                end else if (key_hit) begin
                    mem_we    = 1'b1;
                    mem_wdata = '{occupied: 1'b1, key: word_reg, count: cnt_sat_inc};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_addr] <= mem_wdata;
        end
        if (state_reg == S_READ) begin
            rd_entry_reg <= table_mem[probe_idx_reg];
        end
    end

    //--------------------------------------------------------------------
    // Sequencer: gather bytes, probe the table, hand off the result.
    //--------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_CLEAR;
            clr_idx_reg      <= '0;
            probe_idx_reg    <= '0;
            probe_cnt_reg    <= '0;
            entries_used_reg <= '0;
            word_reg         <= '0;
            word_len_reg     <= '0;
            hash_reg         <= '0;
            ovf_reg          <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // Retire the held result once the receiver takes it; the hand-off
            // state reloads the output register on its own.
            if (m_valid_reg && m_ready && (state_reg != S_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR: begin
                    clr_idx_reg <= clr_idx_reg + SB'(1);
                    if (clr_idx_reg == LAST_SLOT) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        if (word_ends && (word_len_next != 4'd0)) begin
                            // Hold the finished word and start at its home slot.
                            word_reg      <= word_next;
                            word_len_reg  <= word_len_next;
                            hash_reg      <= hash_next;
                            ovf_reg       <= ovf_next;
                            probe_idx_reg <= hash_next[SB-1:0];
                            probe_cnt_reg <= '0;
                            state_reg     <= S_READ;
                        end else if (word_ends) begin
                            word_reg     <= '0;
                            word_len_reg <= '0;
                            hash_reg     <= '0;
                            ovf_reg      <= 1'b0;
                        end else begin
                            word_reg     <= word_next;
                            word_len_reg <= word_len_next;
                            hash_reg     <= hash_next;
                            ovf_reg      <= ovf_next;
                        end
                    end
                end
                S_READ: begin
                    state_reg <= S_CHECK;
                end
                S_CHECK: begin
                    res_reg.truncated   <= ovf_reg;
                    res_reg.word_length <= word_len_reg;
                    if (!rd_entry_reg.occupied) begin
                        res_reg.slot       <= probe_idx_reg;
                        res_reg.count      <= CB'(1);
                        res_reg.is_new     <= 1'b1;
                        res_reg.table_full <= 1'b0;
                        entries_used_reg   <= entries_used_reg + PB'(1);
                        state_reg          <= S_OUT;
                    end else if (key_hit) begin
                        res_reg.slot       <= probe_idx_reg;
                        res_reg.count      <= cnt_sat_inc;
                        res_reg.is_new     <= 1'b0;
                        res_reg.table_full <= 1'b0;
                        state_reg          <= S_OUT;
                    end else if (probe_cnt_reg == LAST_PROBE) begin
                        // Every slot visited: report the home slot, insert nothing.
                        res_reg.slot       <= hash_reg[SB-1:0];
                        res_reg.count      <= '0;
                        res_reg.is_new     <= 1'b0;
                        res_reg.table_full <= 1'b1;
                        state_reg          <= S_OUT;
                    end else begin
                        probe_idx_reg <= probe_idx_reg + SB'(1);
                        probe_cnt_reg <= probe_cnt_reg + PB'(1);
                        state_reg     <= S_READ;
                    end
                end
                S_OUT: begin
                    // Load the output register once it is free, then drop the word.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg  <= 1'b1;
                        m_data_reg   <= res_reg;
                        word_reg     <= '0;
                        word_len_reg <= '0;
                        hash_reg     <= '0;
                        ovf_reg      <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    // A new result only appears as the sequencer leaves its hand-off state.
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside hand-off");

    // Result flags are mutually consistent.
    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((!m_data.is_new || (m_data.count == CB'(1))) &&
                     (!m_data.table_full || ((m_data.count == '0) && !m_data.is_new))))
        else $error("inconsistent result flags");

    // Never more occupied slots than the table holds.
    a_entries_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        entries_used_reg <= SLOT_TOTAL)
        else $error("entry count overran table");

    // A probe never starts on an empty word.
    a_probe_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> ((word_len_reg != 4'd0) && (word_len_reg <= MAX_LEN)))
        else $error("probe with bad word length");

endmodule
